FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    `ASSERT_PROP(name, clk, rst_n, !(expr), msg)

`endif

FILE: hdl/bdw_pkg.sv
// Shared constants and controller/datapath interface types for the word divider.
package bdw_pkg;

    // Width of every payload field on the ports
    localparam int FIELD_BITS = 32;

    // Default working word width
    localparam int WORD_BITS_DEF = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the accepted word and set up the division
        logic step;      // run one restoring division step
        logic out_load;  // move the finished result into the output register
    } bdw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic long_div;  // incoming item needs the double-length pass
    } bdw_status_t;

endpackage

FILE: hdl/bdw_ctrl.sv
// Controller for the word divider: handshakes, step counter and state machine.
`include "assert_macros.svh"

module bdw_ctrl
    import bdw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  bdw_status_t status,
    output bdw_cmd_t    cmd
);

    localparam int CNT_W = $clog2(2 * WORD_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_SHORT = CNT_W'(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LONG  = CNT_W'(2 * WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequence one item: accept, iterate, hand over to the output register
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = status.long_div ? CNT_LONG : CNT_SHORT;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set valid on a new result, drop it once the transaction completes
    always_comb
    begin
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && m_tvalid_reg && !m_tready,
        "pending result overwritten")
    `ASSERT_PROP(a_accept_runs, clk, rst_n, (s_tvalid && s_tready) |=> (state_reg == S_RUN),
        "accepted item did not start iterating")
    `ASSERT_NEVER(a_run_count, clk, rst_n, (state_reg == S_RUN) && (cnt_reg == '0),
        "iteration with empty step count")

endmodule

FILE: hdl/bdw_datapath.sv
// Datapath for the word divider: held divisor, running remainder and restoring step.
`include "assert_macros.svh"

module bdw_datapath
    import bdw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bdw_cmd_t              cmd,
    output bdw_status_t           status,
    input  logic [FIELD_BITS-1:0] dividend_word,
    input  logic                  first_word,
    input  logic                  last_word,
    input  logic [FIELD_BITS-1:0] divisor_in,
    input  logic [FIELD_BITS-1:0] carry_in,
    output logic [FIELD_BITS-1:0] quotient_word,
    output logic [FIELD_BITS-1:0] remainder_out,
    output logic                  last_out
);

    localparam int W = WORD_BITS;

    logic [W-1:0]   div_reg, div_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [2*W-1:0] sh_reg, sh_next;
    logic [W-1:0]   q_reg, q_next;
    logic           last_reg, last_next;
    logic [W-1:0]   q_out_reg, rem_out_reg;
    logic           last_out_reg;

    logic [W-1:0]   word_w, div_w, carry_w, div_fix;
    logic           long_div;
    logic [W:0]     trial, diff;
    logic           ge;

    // Take the low word bits of the inputs; a zero divisor counts as one
    assign word_w   = dividend_word[W-1:0];
    assign div_w    = divisor_in[W-1:0];
    assign carry_w  = carry_in[W-1:0];
    assign div_fix  = (div_w == '0) ? W'(1) : div_w;
    assign long_div = first_word && (carry_w >= div_fix);
    assign status.long_div = long_div;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, sh_reg[2*W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb
    begin
        div_next  = div_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            last_next = last_word;
            q_next    = '0;
            if (first_word)
            begin
                div_next = div_fix;
            end
            if (long_div)
            begin
                // Carry-in not below the divisor: divide the full double word
                rem_next = '0;
                sh_next  = {carry_w, word_w};
            end
            else
            begin
                rem_next = first_word ? carry_w : rem_reg;
                sh_next  = {word_w, {W{1'b0}}};
            end
        end
        else if (cmd.step)
        begin
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            sh_next  = {sh_reg[2*W-2:0], 1'b0};
            q_next   = {q_reg[W-2:0], ge};
        end
    end

    // Hold divisor and remainder across items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg <= W'(1);
            rem_reg <= '0;
        end
        else
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        q_reg    <= q_next;
        last_reg <= last_next;
        if (cmd.out_load)
        begin
            q_out_reg    <= q_reg;
            rem_out_reg  <= rem_reg;
            last_out_reg <= last_reg;
        end
    end

    assign quotient_word = FIELD_BITS'(q_out_reg);
    assign remainder_out = FIELD_BITS'(rem_out_reg);
    assign last_out      = last_out_reg;

    `ASSERT_PROP(a_rem_below_div, clk, rst_n, cmd.out_load |-> (rem_reg < div_reg),
        "remainder not below divisor at result")

endmodule

FILE: hdl/bignum_divide_by_word.sv
// Top level of the multiprecision divider by one word.
//
//  channel  dir  tdata (low bit up)                          tuser       tlast
//  s_*      in   dividend_word, divisor_in, carry_in (96b)   first_word  last_word
//  m_*      out  quotient_word, remainder_out (64b)          -           last_out
//
// The accepting edge loads an item, one restoring step per quotient bit follows, and then
// the result moves into the output register; the next item is accepted only after that
// handover. A first word whose carry-in is not below the divisor runs 2 * WORD_BITS steps.
// Reset gives divisor one and remainder zero; the input is ready at once.
// A stalled output holds its result while the next item is accepted and divided;
// that item waits for the output register to free before it is handed over.
module bignum_divide_by_word
    import bdw_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // dividend_word, divisor_in, carry_in
    input  logic        s_tuser,   // first_word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // quotient_word, remainder_out
    output logic        m_tlast
);

    bdw_cmd_t    cmd;
    bdw_status_t status;

    logic [FIELD_BITS-1:0] quotient_word;
    logic [FIELD_BITS-1:0] remainder_out;

    bdw_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdw_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .dividend_word (s_tdata[31:0]),
        .first_word    (s_tuser),
        .last_word     (s_tlast),
        .divisor_in    (s_tdata[63:32]),
        .carry_in      (s_tdata[95:64]),
        .quotient_word (quotient_word),
        .remainder_out (remainder_out),
        .last_out      (m_tlast)
    );

    assign m_tdata = {remainder_out, quotient_word};

endmodule

FILE: dv/bignum_divide_by_word_tb.sv
// Self-checking testbench for the multiword divider by one 32-bit word.
`timescale 1ns / 1ps

module bignum_divide_by_word_tb;
    import bdw_pkg::*;

    localparam int WB           = FIELD_BITS;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_MAX   = 10;

    typedef logic [WB-1:0] word_t;

    typedef struct packed {
        word_t quotient;
        word_t remainder;
        logic  last;
    } quot_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // dividend_word, divisor_in, carry_in
    logic        s_tuser;   // first_word
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // quotient_word, remainder_out
    logic        m_tlast;

    // Predictor state: divisor and remainder carried from word to word
    word_t held_divisor;
    word_t running_rem;

    quot_word_t pending_quotients[$];
    int         src_idle_pct  = 16;
    int         sink_idle_pct = 87;
    int         mismatches    = 0;
    int         stall_cycles  = 0;

    bignum_divide_by_word i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // Divide (running remainder : word) by the held divisor, one quotient word out
    function automatic quot_word_t divide_word(input word_t word, input logic first,
                                               input logic last, input word_t divisor,
                                               input word_t carry);
        logic [2*WB-1:0] wide;
        logic [2*WB-1:0] quot;
        quot_word_t      res;
        if (first)
        begin
            held_divisor = (divisor == '0) ? word_t'(1) : divisor;
            running_rem  = carry;
        end
        wide          = {running_rem, word};
        quot          = wide / held_divisor;
        running_rem   = word_t'(wide % held_divisor);
        res.quotient  = quot[WB-1:0];
        res.remainder = running_rem;
        res.last      = last;
        return res;
    endfunction

    // Pick a word biased toward edge values
    function automatic word_t rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'(1) << $urandom_range(WB - 1);
            3:       return word_t'($urandom_range(15));
            4:       return ~word_t'($urandom_range(15));
            default: return word_t'($urandom);
        endcase
    endfunction

    // Count a mismatch and report the first few
    task automatic check_field(input string name, input word_t want, input word_t got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t %s: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // Send one word, optionally after idle cycles; returns at the falling edge
    task automatic send_word(input word_t word, input logic first, input logic last,
                             input word_t divisor, input word_t carry);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom, $urandom};
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {carry, divisor, word};
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_quotients.push_back(divide_word(word, first, last, divisor, carry));
        @(negedge clk);
    endtask

    // Send a number of random words; divisor and carry ride on the first word only
    task automatic send_number(input int words, input logic first_mark, input logic last_mark,
                               input word_t divisor, input word_t carry);
        for (int i = 0; i < words; i++)
        begin
            if (i == 0 && first_mark)
                send_word(rand_word(), 1'b1, last_mark && words == 1, divisor, carry);
            else
                send_word(rand_word(), 1'b0, last_mark && i == words - 1,
                          word_t'($urandom), word_t'($urandom));
        end
    endtask

    // Words without a first mark straight after reset use divisor one, remainder zero
    task automatic test_reset_state();
        send_word(32'h9abc_def0, 1'b0, 1'b0, 32'h0000_0007, 32'h0000_0003);
        send_word(32'hffff_ffff, 1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
    endtask

    // One-word numbers at the extremes of divisor, carry-in and word
    task automatic test_single_word();
        send_word(32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000);
        send_word(32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_fffe);
        send_word(32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0000, 32'hffff_ffff);
        send_word(32'hffff_ffff, 1'b1, 1'b1, 32'h0000_0001, 32'h0000_0000);
        send_word(32'h0000_0000, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        send_word(32'h1234_5678, 1'b1, 1'b1, 32'h8000_0000, 32'h7fff_ffff);
    endtask

    // Multiword numbers: plain, continued without a first mark, oversized carry, restart
    task automatic test_multi_word();
        send_number(4, 1'b1, 1'b1, 32'h0001_0001, 32'h0000_0000);
        send_number(2, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
        send_number(4, 1'b1, 1'b1, 32'h0000_0003, 32'hffff_ffff);
        send_number(2, 1'b1, 1'b0, 32'h0000_000a, 32'h0000_0009);
        send_number(3, 1'b1, 1'b1, 32'hffff_fff1, 32'h8000_0000);
    endtask

    // Random numbers of random length under one idle setting
    task automatic test_random_numbers(input int src_pct, input int sink_pct, input int items);
        int    sent;
        int    len;
        int    kind;
        word_t divisor;
        word_t carry;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent          = 0;
        while (sent < items)
        begin
            len     = ($urandom_range(19) == 0) ? 64 : $urandom_range(1, 16);
            kind    = $urandom_range(9);
            divisor = rand_word();
            if ($urandom_range(7) == 0 || divisor == '0)
                carry = rand_word();
            else
                carry = rand_word() % divisor;
            // Mostly well-formed numbers; some lack the first or the last mark
            send_number(len, kind != 0, kind != 1, divisor, carry);
            sent += len;
        end
    endtask

    // Drive the receiver's ready at random
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        quot_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_quotients.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t unexpected result %h last %b", $realtime, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_quotients.pop_front();
                check_field("quotient_word", want.quotient, m_tdata[WB-1:0]);
                check_field("remainder_out", want.remainder, m_tdata[2*WB-1:WB]);
                check_field("last_out", word_t'(want.last), word_t'(m_tlast));
            end
        end
    end

    // End the run when nothing moves while work is outstanding
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (!s_tvalid && pending_quotients.size() == 0))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("bignum_divide_by_word: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        held_divisor = word_t'(1);
        running_rem  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_single_word();
        test_multi_word();
        test_random_numbers(16, 87, 660);
        test_random_numbers(87, 16, 660);
        test_random_numbers(0, 0, 680);

        // Drop valid and drain
        s_tvalid <= 1'b0;
        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("bignum_divide_by_word: match");
        else
            $display("bignum_divide_by_word: mismatch");
        $finish;
    end

endmodule
